// ----- src/tfp_pkg.sv -----
// Shared types and field widths for the task queue with tag purge.
`timescale 1ns / 1ps

package tfp_pkg;

    // Fixed widths of the request and result fields.
    localparam int OP_W      = 2;
    localparam int TAG_IN_W  = 8;
    localparam int COMP_W    = 16;
    localparam int TAG_OUT_W = 8;
    localparam int OCC_W     = 9;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PURGE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // Per-cycle commands broadcast along the cell chain.
    typedef struct packed {
        logic push;   // cell at the tail index loads the pushed entry
        logic shift;  // every cell takes its upper neighbour's entry
        logic keep;   // during purge: cell at tail-1 takes the head entry
    } t_cell_ctl;

endpackage

// ----- src/task_fifo_with_tag_purge.sv -----
// Top level of the task queue with tag purge: control and the cell chain.
`timescale 1ns / 1ps

// Task queue of DEPTH entries (owner tag, component index) kept in a chain
// of cells with the head always in cell 0. Push, pop and clear take one
// request per cycle and answer with one result each; the result shows
// whether the request took effect, the head entry and the occupancy after
// it. A purge request walks the queue through the head cell once, one
// entry per cycle: survivors recirculate to the tail in order, matches are
// dropped. During the walk s_axis_tready is low. A new request is taken
// as soon as the previous result has been taken or is taken in the same
// cycle. No clearing pass follows reset.
module task_fifo_with_tag_purge #(
    parameter int DEPTH    = 256,
    parameter int TAG_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op[1:0], owner_tag[9:2], component_index[25:10]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // accepted[0], head_valid[1], head_tag[9:2],
                                        // head_component[25:10], occupancy[34:26]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = (TAG_BITS < tfp_pkg::TAG_OUT_W) ? TAG_BITS : tfp_pkg::TAG_OUT_W;
    localparam int EW = TW + tfp_pkg::COMP_W;

    typedef enum logic {
        ST_IDLE,
        ST_PURGE
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_left, n_left;
    logic [TW-1:0]               r_tag, n_tag;
    logic                        r_out_valid, n_out_valid;
    logic                        r_acc, n_acc;

    tfp_pkg::t_cell_ctl          w_ctl;
    logic                        w_s_hs;
    logic [tfp_pkg::OP_W-1:0]    w_op;
    logic [TW-1:0]               w_tag;
    logic [tfp_pkg::COMP_W-1:0]  w_comp;
    logic [EW-1:0]               w_push_entry;
    logic [CW-1:0]               w_rot_idx;
    logic                        w_full;
    logic                        w_empty;
    logic [EW-1:0]               w_entry [DEPTH];
    logic [EW-1:0]               w_next  [DEPTH];

    // request fields
    assign w_op         = s_axis_tdata[1:0];
    assign w_tag        = s_axis_tdata[TW+1:2];
    assign w_comp       = s_axis_tdata[25:10];
    assign w_push_entry = {w_comp, w_tag};

    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_rot_idx = r_count - CW'(1);

    // one request in flight; output register must be free or draining
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_s_hs        = s_axis_tvalid && s_axis_tready;

    // cell chain, head in cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_top
            assign w_next[g] = '0;
        end else begin : g_mid
            assign w_next[g] = w_entry[g+1];
        end

        tfp_cell #(
            .EW    (EW),
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_push_idx (r_count),
            .i_rot_idx  (w_rot_idx),
            .i_next     (w_next[g]),
            .i_head     (w_entry[0]),
            .i_push     (w_push_entry),
            .o_entry    (w_entry[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_tag       = r_tag;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_ctl       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_s_hs) begin
                    case (w_op)
                        tfp_pkg::OP_PUSH: begin
                            n_out_valid = 1'b1;
                            n_acc       = !w_full;
                            if (!w_full) begin
                                w_ctl.push = 1'b1;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        tfp_pkg::OP_POP: begin
                            n_out_valid = 1'b1;
                            n_acc       = !w_empty;
                            if (!w_empty) begin
                                w_ctl.shift = 1'b1;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        tfp_pkg::OP_PURGE: begin
                            // result is given once the walk is done
                            n_state = ST_PURGE;
                            n_left  = r_count;
                            n_tag   = w_tag;
                        end
                        tfp_pkg::OP_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_acc       = 1'b1;
                            n_count     = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_acc       = 1'b1;
                            n_count     = '0;
                        end
                    endcase
                end
            end
            ST_PURGE: begin
                if (r_left == '0) begin
                    n_out_valid = 1'b1;
                    n_acc       = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    // head leaves cell 0; survivors go back in at the tail
                    w_ctl.shift = 1'b1;
                    n_left      = r_left - CW'(1);
                    if (w_entry[0][TW-1:0] != r_tag) begin
                        w_ctl.keep = 1'b1;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_acc       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
        end
        r_tag <= n_tag;
    end

    // result: state only changes when a new request is taken, so the
    // head cell and count still describe the pending result
    logic                          w_head_valid;
    logic [tfp_pkg::TAG_OUT_W-1:0] w_head_tag;
    logic [tfp_pkg::COMP_W-1:0]    w_head_comp;

    assign w_head_valid = !w_empty;
    assign w_head_tag   = w_empty ? '0 : tfp_pkg::TAG_OUT_W'(w_entry[0][TW-1:0]);
    assign w_head_comp  = w_empty ? '0 : w_entry[0][EW-1:TW];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, tfp_pkg::OCC_W'(r_count), w_head_comp, w_head_tag,
                            w_head_valid, r_acc};

endmodule

// ----- src/tfp_cell.sv -----
// One storage cell of the queue chain: holds an entry, shifts towards the head.
`timescale 1ns / 1ps

module tfp_cell #(
    parameter int EW    = 24,
    parameter int CW    = 9,
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  tfp_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]        i_push_idx,
    input  logic [CW-1:0]        i_rot_idx,
    input  logic [EW-1:0]        i_next,
    input  logic [EW-1:0]        i_head,
    input  logic [EW-1:0]        i_push,
    output logic [EW-1:0]        o_entry
);

    logic [EW-1:0] r_entry;
    logic [EW-1:0] n_entry;
    logic          w_here_push;
    logic          w_here_rot;

    assign w_here_push = (i_push_idx == CW'(INDEX));
    assign w_here_rot  = (i_rot_idx == CW'(INDEX));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push && w_here_push) begin
            n_entry = i_push;
        end else if (i_ctl.shift && i_ctl.keep && w_here_rot) begin
            // survivor of a purge step recirculates to the tail
            n_entry = i_head;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- verif/task_fifo_with_tag_purge_test.sv -----
// Testbench for the task queue with tag purge: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module task_fifo_with_tag_purge_test;

    localparam int QUEUE_DEPTH  = 256;
    localparam int REQUEST_GOAL = 1700;
    localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake on either side
    localparam int HOLD_AT      = 1000;  // request count at which the receiver holds off
    localparam int HOLD_CYCLES  = 320;
    localparam int CALM_FROM    = 500;   // window with no idling on either side
    localparam int CALM_TO      = 800;

    typedef enum logic [tfp_pkg::OP_W-1:0] {
        OP_PUSH  = tfp_pkg::OP_PUSH,
        OP_POP   = tfp_pkg::OP_POP,
        OP_PURGE = tfp_pkg::OP_PURGE,
        OP_CLEAR = tfp_pkg::OP_CLEAR
    } t_op;

    // request word, lowest field in the lowest bits
    typedef struct packed {
        logic [5:0]                   pad;
        logic [tfp_pkg::COMP_W-1:0]   component_index;
        logic [tfp_pkg::TAG_IN_W-1:0] owner_tag;
        t_op                          op;
    } t_request;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]                    pad;
        logic [tfp_pkg::OCC_W-1:0]     occupancy;
        logic [tfp_pkg::COMP_W-1:0]    head_component;
        logic [tfp_pkg::TAG_OUT_W-1:0] head_tag;
        logic                          head_valid;
        logic                          accepted;
    } t_result;

    typedef struct packed {
        logic [tfp_pkg::TAG_IN_W-1:0] tag;
        logic [tfp_pkg::COMP_W-1:0]   component;
    } t_task;

    // Tracks the queue contents in order from the head and holds the results still due.
    class task_queue_checker;
        t_task   held[$];
        t_result due_results[$];
        int      mismatches;
        int      strays;

        function new();
            mismatches = 0;
            strays     = 0;
        endfunction

        // Applies an accepted request to the queue copy and files the result it must give.
        function void note_request(t_request req);
            t_task   survivors[$];
            t_result want;
            want = '0;
            case (req.op)
                OP_PUSH: begin
                    if (held.size() < QUEUE_DEPTH) begin
                        held.push_back({req.owner_tag, req.component_index});
                        want.accepted = 1'b1;
                    end
                end
                OP_POP: begin
                    if (held.size() != 0) begin
                        void'(held.pop_front());
                        want.accepted = 1'b1;
                    end
                end
                OP_PURGE: begin
                    // survivors keep their order from the head
                    foreach (held[i])
                        if (held[i].tag != req.owner_tag)
                            survivors.push_back(held[i]);
                    held = survivors;
                    want.accepted = 1'b1;
                end
                default: begin
                    held.delete();
                    want.accepted = 1'b1;
                end
            endcase
            if (held.size() != 0) begin
                want.head_valid     = 1'b1;
                want.head_tag       = held[0].tag;
                want.head_component = held[0].component;
            end
            want.occupancy = tfp_pkg::OCC_W'(held.size());
            due_results.push_back(want);
        endfunction

        function void check_result(logic [39:0] raw);
            t_result got;
            t_result want;
            got = raw;
            if (due_results.size() == 0) begin
                strays++;
                if (strays + mismatches <= 10)
                    $display("%0t: result with nothing due: %h", $time, raw);
                return;
            end
            want = due_results.pop_front();
            if (got.accepted != want.accepted || got.head_valid != want.head_valid ||
                got.head_tag != want.head_tag || got.head_component != want.head_component ||
                got.occupancy != want.occupancy || got.pad != want.pad) begin
                mismatches++;
                if (strays + mismatches <= 10)
                    $display("%0t: acc %b/%b valid %b/%b tag %h/%h comp %h/%h occ %0d/%0d pad %h/%h",
                             $time, want.accepted, got.accepted, want.head_valid,
                             got.head_valid, want.head_tag, got.head_tag,
                             want.head_component, got.head_component,
                             want.occupancy, got.occupancy, want.pad, got.pad);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // op[1:0], owner_tag[9:2], component_index[25:10]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // accepted[0], head_valid[1], head_tag[9:2],
                                 // head_component[25:10], occupancy[34:26]

    task_queue_checker sb;
    int                requests_sent;
    int                results_taken;
    int                quiet_cycles;
    bit                hold_done;
    logic [7:0]        tag_pool [4];

    task_fifo_with_tag_purge #(
        .DEPTH    (QUEUE_DEPTH),
        .TAG_BITS (8)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Idling on either side, except inside the calm window.
    function automatic bit takes_a_rest(int count);
        return !(count >= CALM_FROM && count < CALM_TO) && ($urandom_range(0, 99) < 36);
    endfunction

    function automatic logic [7:0] rand_tag();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_comp();
        return 16'($urandom_range(0, 65535));
    endfunction

    // Handshake monitor: results are checked before the request of the same edge is noted,
    // since a result never belongs to a request taken on that same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                results_taken++;
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off so the pending result
    // stays and the block stops taking requests.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && requests_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= i_rst_n && !takes_a_rest(results_taken);
            end
        end
    end

    // Offers one request, idling first at random; returns at the edge where it is taken.
    task automatic send(t_op op, logic [7:0] tag, logic [15:0] comp);
        t_request req;
        bit       resting;
        req = '0;
        req.op              = op;
        req.owner_tag       = tag;
        req.component_index = comp;
        resting = 1'b1;
        while (resting) begin
            @(negedge i_clk);
            resting = takes_a_rest(requests_sent);
            if (resting)
                s_axis_tvalid <= 1'b0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // Four neighbouring tags, so purges hit often and runs of equal tags occur.
    task automatic new_tag_pool();
        logic [7:0] base;
        base = rand_tag();
        foreach (tag_pool[i])
            tag_pool[i] = base + 8'(i);
    endtask

    // Mostly a pool tag; now and then any tag at all.
    function automatic logic [7:0] pick_tag();
        if ($urandom_range(0, 99) < 85)
            return tag_pool[2'($urandom_range(0, 3))];
        return rand_tag();
    endfunction

    task automatic send_push_run(int n);
        repeat (n) send(OP_PUSH, tag_pool[2'($urandom_range(0, 3))], rand_comp());
    endtask

    // Fill to the brim, try to overfill, purge while full, then push, pop and push again
    // so the queue contents move on before purging again.
    task automatic fill_and_wrap();
        new_tag_pool();
        send(OP_CLEAR, rand_tag(), rand_comp());
        send_push_run(QUEUE_DEPTH + 3);
        send(OP_PURGE, tag_pool[3] + 8'd1, rand_comp());  // tag not present
        send(OP_PUSH, pick_tag(), rand_comp());           // still full
        send(OP_PURGE, tag_pool[1], rand_comp());
        send_push_run(80);
        repeat (100) send(OP_POP, rand_tag(), rand_comp());
        send_push_run(100);
        send(OP_PURGE, tag_pool[2], rand_comp());
        send(OP_PURGE, tag_pool[0], rand_comp());
        repeat (10) send(OP_POP, rand_tag(), rand_comp());
        send(OP_PURGE, tag_pool[3], rand_comp());
    endtask

    // A run of mixed requests; whatever is left of a hundred after the three weights
    // goes to clears.
    task automatic send_mix(int len, int push_w, int pop_w, int purge_w);
        int roll;
        repeat (len) begin
            roll = $urandom_range(0, 99);
            if (roll < push_w)
                send(OP_PUSH, pick_tag(), rand_comp());
            else if (roll < push_w + pop_w)
                send(OP_POP, rand_tag(), rand_comp());
            else if (roll < push_w + pop_w + purge_w)
                send(OP_PURGE, pick_tag(), rand_comp());
            else
                send(OP_CLEAR, rand_tag(), rand_comp());
        end
    endtask

    initial begin
        int kind;
        sb            = new();
        requests_sent = 0;
        results_taken = 0;
        quiet_cycles  = 0;
        hold_done     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-queue cases, field extremes, adjacent matches, purge to empty
        send(OP_POP,   8'h00, 16'h0000);   // pop when empty is ignored
        send(OP_PURGE, 8'hFF, 16'hFFFF);   // purge on empty queue
        send(OP_PUSH,  8'h00, 16'h0000);
        send(OP_PUSH,  8'hFF, 16'hFFFF);
        send(OP_PUSH,  8'hAA, 16'h5555);
        send(OP_PUSH,  8'hAA, 16'hAAAA);
        send(OP_PUSH,  8'hAA, 16'h0F0F);
        send(OP_PUSH,  8'h55, 16'hF0F0);
        send(OP_PUSH,  8'hAA, 16'h1234);
        send(OP_PURGE, 8'hAA, 16'h0000);   // three adjacent matches and a lone one
        send(OP_POP,   8'h55, 16'hAAAA);
        send(OP_PURGE, 8'hFF, 16'h5555);   // purge hits the head
        send(OP_CLEAR, 8'h00, 16'h0000);
        send(OP_POP,   8'hFF, 16'hFFFF);
        send(OP_PUSH,  8'h01, 16'h8001);
        send(OP_PUSH,  8'h01, 16'h0180);
        send(OP_PURGE, 8'h01, 16'h0000);   // purge leaves it empty
        send(OP_PUSH,  8'h80, 16'h7FFE);
        send(OP_CLEAR, 8'hFF, 16'hFFFF);

        fill_and_wrap();

        while (requests_sent < REQUEST_GOAL) begin
            new_tag_pool();
            kind = $urandom_range(0, 9);
            if (kind < 3)
                send_mix($urandom_range(20, 60), 75, 12, 10);
            else if (kind < 5)
                send_mix($urandom_range(20, 60), 25, 55, 17);
            else
                send_mix($urandom_range(20, 60), 50, 30, 17);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.strays == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
